### hw/rtl/sm64_pkg.sv
// ----------------------------------------------------------------------------
// sm64_pkg
// Shared types and constants of the splitmix64 generator engine: command
// codes, datapath operations, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package sm64_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned BOUND_W   = 63;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IN_DATA_W  = 256;
  localparam int unsigned OUT_DATA_W = 320;

  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;

  // tries of a bounded draw before the fallback fold
  localparam int unsigned RETRY_LIMIT = 1024;
  localparam int unsigned TRY_W       = $clog2(RETRY_LIMIT);

  typedef enum logic [CMD_W-1:0] {
    CMD_NEXT    = 2'd0,
    CMD_BOUNDED = 2'd1,
    CMD_SPLIT   = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_t;

  // which finalizer the shared multiplier works for
  typedef enum logic {
    MIX_MURMUR,
    MIX_STAFFORD
  } mix_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_ADV,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_DRAW,
    DP_EQ,
    DP_BSETUP,
    DP_BMASK,
    DP_CHECK,
    DP_RESOLVE,
    DP_CSEED,
    DP_CGAM,
    DP_CGCNT,
    DP_CGFIX,
    DP_LOAD,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADV,
    S_M0,
    S_M1,
    S_M2,
    S_POST,
    S_BSETUP,
    S_BMASK,
    S_JUDGE,
    S_CGCNT,
    S_CGFIX,
    S_FINISH
  } state_t;

  typedef struct packed {
    dp_op_t op;
    mix_t   fn;
    logic   stage;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic bounds_eq;
    logic hit;
    logic out_full;
  } dp_stat_t;

endpackage

### hw/rtl/sm64_dp.sv
// ----------------------------------------------------------------------------
// sm64_dp
// Datapath: seed and gamma state, one shared 32x32 multiplier for the mix
// finalizers, bounded-draw range logic, child gamma check and output register.
// ----------------------------------------------------------------------------
module sm64_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sm64_pkg::dp_cmd_t             dp_cmd,
  output sm64_pkg::dp_stat_t            dp_stat,
  input  logic [sm64_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [sm64_pkg::CMD_W-1:0]    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sm64_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sm64_pkg::*;

  localparam logic [WORD_W-1:0] K_MUR0 = 64'hff51afd7ed558ccd;
  localparam logic [WORD_W-1:0] K_MUR1 = 64'hc4ceb9fe1a85ec53;
  localparam logic [WORD_W-1:0] K_STA0 = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] K_STA1 = 64'h94d049bb133111eb;
  localparam logic [WORD_W-1:0] FLIP   = 64'haaaaaaaaaaaaaaaa;
  localparam logic [6:0]        MIN_TRANS = 7'd24;

  function automatic logic [WORD_W-1:0] xs_in(input logic [WORD_W-1:0] v,
                                               input mix_t fn, input logic stage);
    logic [WORD_W-1:0] r;
    r = v ^ (v >> 33);
    if (fn == MIX_STAFFORD) begin
      r = stage ? (v ^ (v >> 27)) : (v ^ (v >> 30));
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] k_of(input mix_t fn, input logic stage);
    logic [WORD_W-1:0] r;
    r = stage ? K_MUR1 : K_MUR0;
    if (fn == MIX_STAFFORD) begin
      r = stage ? K_STA1 : K_STA0;
    end
    return r;
  endfunction

  function automatic logic [BOUND_W-1:0] width_mask(input logic [BOUND_W-1:0] r);
    logic [BOUND_W-1:0] m;
    m = r;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    m = m | (m >> 32);
    return m;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, b[i]};
    end
    return n;
  endfunction

  logic [WORD_W-1:0]  seed_r, seed_nxt;
  logic [WORD_W-1:0]  gamma_r, gamma_nxt;
  logic [WORD_W-1:0]  v_r;
  logic [WORD_W-1:0]  acc_r;
  cmd_t               cmd_r;
  logic [BOUND_W-1:0] a_r, b_r;
  logic [WORD_W-1:0]  lds_r, ldg_r;
  logic [BOUND_W-1:0] base_r, range_r;
  logic [WORD_W-1:0]  mask_r, nbase_r, x_r;
  logic               hit_r;
  logic [WORD_W-1:0]  draw_r, cseed_r, cgamma_r;
  logic [3:0]         bc_r [8];
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  o_draw_r, o_cseed_r, o_cgamma_r, o_seed_r, o_gamma_r;

  logic [WORD_W-1:0]   opnd, kval, fin, xmask, adv, trans;
  logic [31:0]         mul_a, mul_b;
  logic [2*32-1:0]     prod;
  logic [6:0]          trans_cnt;
  logic                a_lt;

  assign opnd  = xs_in(v_r, dp_cmd.fn, dp_cmd.stage);
  assign kval  = k_of(dp_cmd.fn, dp_cmd.stage);
  assign mul_a = (dp_cmd.op == DP_MUL2) ? opnd[63:32] : opnd[31:0];
  assign mul_b = (dp_cmd.op == DP_MUL1) ? kval[63:32] : kval[31:0];
  assign prod  = mul_a * mul_b;

  assign fin   = (dp_cmd.fn == MIX_STAFFORD) ? (v_r ^ (v_r >> 31)) : (v_r ^ (v_r >> 33));
  assign xmask = fin & mask_r;
  assign adv   = seed_r + gamma_r;
  assign a_lt  = a_r < b_r;
  assign trans = cgamma_r ^ (cgamma_r >> 1);

  always_comb begin
    trans_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      trans_cnt = trans_cnt + {3'b000, bc_r[i]};
    end
  end

  always_comb begin
    seed_nxt  = seed_r;
    gamma_nxt = gamma_r;
    case (dp_cmd.op)
      DP_ADV:  seed_nxt = adv;
      DP_LOAD: begin
        seed_nxt  = lds_r;
        gamma_nxt = ldg_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (dp_cmd.op == DP_EMIT) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      gamma_r     <= GOLDEN_GAMMA;
      out_valid_r <= 1'b0;
    end else begin
      seed_r      <= seed_nxt;
      gamma_r     <= gamma_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      DP_CAPTURE: begin
        cmd_r    <= cmd_t'(in_tuser);
        a_r      <= in_tdata[62:0];
        b_r      <= in_tdata[125:63];
        lds_r    <= in_tdata[189:126];
        ldg_r    <= in_tdata[253:190];
        draw_r   <= '0;
        cseed_r  <= '0;
        cgamma_r <= '0;
      end
      DP_ADV:  v_r <= adv;
      DP_MUL0: acc_r <= prod;
      DP_MUL1: acc_r[63:32] <= acc_r[63:32] + prod[31:0];
      DP_MUL2: v_r <= {acc_r[63:32] + prod[31:0], acc_r[31:0]};
      DP_DRAW: draw_r <= fin;
      DP_EQ:   draw_r <= {1'b0, a_r};
      DP_BSETUP: begin
        base_r  <= a_lt ? a_r : b_r;
        range_r <= a_lt ? (b_r - a_r) : (a_r - b_r);
      end
      DP_BMASK: begin
        mask_r  <= {1'b0, width_mask(range_r)};
        // base - (range + 1), used when every try was rejected
        nbase_r <= {1'b0, base_r} + ~{1'b0, range_r};
      end
      DP_CHECK: begin
        x_r   <= xmask;
        hit_r <= xmask <= {1'b0, range_r};
      end
      DP_RESOLVE: draw_r <= (hit_r ? {1'b0, base_r} : nbase_r) + x_r;
      DP_CSEED:   cseed_r <= fin;
      DP_CGAM:    cgamma_r <= fin | 64'd1;
      DP_CGCNT: begin
        for (int i = 0; i < 8; i++) begin
          bc_r[i] <= pop8(trans[i*8 +: 8]);
        end
      end
      DP_CGFIX: begin
        if (trans_cnt < MIN_TRANS) begin
          cgamma_r <= cgamma_r ^ FLIP;
        end
      end
      DP_EMIT: begin
        o_draw_r   <= draw_r;
        o_cseed_r  <= cseed_r;
        o_cgamma_r <= cgamma_r;
        o_seed_r   <= seed_r;
        o_gamma_r  <= gamma_r;
      end
      default: ;
    endcase
  end

  assign dp_stat.cmd       = cmd_r;
  assign dp_stat.bounds_eq = a_r == b_r;
  assign dp_stat.hit       = hit_r;
  assign dp_stat.out_full  = out_valid_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_gamma_r, o_seed_r, o_cgamma_r, o_cseed_r, o_draw_r};

endmodule

### hw/rtl/sm64_ctrl.sv
// ----------------------------------------------------------------------------
// sm64_ctrl
// Controller: sequences the datapath through capture, seed advance, the
// three-step multiplies of each mix round, rejection retries and result emit.
// ----------------------------------------------------------------------------
module sm64_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               out_tready,
  input  sm64_pkg::dp_stat_t dp_stat,
  output sm64_pkg::dp_cmd_t  dp_cmd
);
  import sm64_pkg::*;

  state_t           state_r, state_nxt;
  logic             stage_r, stage_nxt;
  logic             phase_r, phase_nxt;
  logic [TRY_W-1:0] tries_r, tries_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stage_r <= 1'b0;
      phase_r <= 1'b0;
      tries_r <= '0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      phase_r <= phase_nxt;
      tries_r <= tries_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    stage_nxt    = stage_r;
    phase_nxt    = phase_r;
    tries_nxt    = tries_r;
    in_tready    = 1'b0;
    dp_cmd.op    = DP_NOP;
    dp_cmd.stage = stage_r;
    // second half of a split runs the stafford mix
    dp_cmd.fn    = (dp_stat.cmd == CMD_SPLIT && phase_r) ? MIX_STAFFORD : MIX_MURMUR;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        phase_nxt = 1'b0;
        if (in_tvalid) begin
          dp_cmd.op = DP_CAPTURE;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (dp_stat.cmd)
          CMD_BOUNDED: begin
            if (dp_stat.bounds_eq) begin
              dp_cmd.op = DP_EQ;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_BSETUP;
            end
          end
          CMD_LOAD: begin
            dp_cmd.op = DP_LOAD;
            state_nxt = S_FINISH;
          end
          default: state_nxt = S_ADV;
        endcase
      end
      S_ADV: begin
        dp_cmd.op = DP_ADV;
        stage_nxt = 1'b0;
        state_nxt = S_M0;
      end
      S_M0: begin
        dp_cmd.op = DP_MUL0;
        state_nxt = S_M1;
      end
      S_M1: begin
        dp_cmd.op = DP_MUL1;
        state_nxt = S_M2;
      end
      S_M2: begin
        dp_cmd.op = DP_MUL2;
        stage_nxt = 1'b1;
        state_nxt = stage_r ? S_POST : S_M0;
      end
      S_POST: begin
        case (dp_stat.cmd)
          CMD_BOUNDED: begin
            dp_cmd.op = DP_CHECK;
            state_nxt = S_JUDGE;
          end
          CMD_SPLIT: begin
            if (phase_r) begin
              dp_cmd.op = DP_CGAM;
              state_nxt = S_CGCNT;
            end else begin
              dp_cmd.op = DP_CSEED;
              phase_nxt = 1'b1;
              state_nxt = S_ADV;
            end
          end
          default: begin
            dp_cmd.op = DP_DRAW;
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_BSETUP: begin
        dp_cmd.op = DP_BSETUP;
        tries_nxt = '0;
        state_nxt = S_BMASK;
      end
      S_BMASK: begin
        dp_cmd.op = DP_BMASK;
        state_nxt = S_ADV;
      end
      S_JUDGE: begin
        if (dp_stat.hit || tries_r == TRY_W'(RETRY_LIMIT - 1)) begin
          dp_cmd.op = DP_RESOLVE;
          state_nxt = S_FINISH;
        end else begin
          tries_nxt = tries_r + 1'b1;
          state_nxt = S_ADV;
        end
      end
      S_CGCNT: begin
        dp_cmd.op = DP_CGCNT;
        state_nxt = S_CGFIX;
      end
      S_CGFIX: begin
        dp_cmd.op = DP_CGFIX;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!dp_stat.out_full || out_tready) begin
          dp_cmd.op = DP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### hw/rtl/splitmix64_generator_engine_core.sv
// ----------------------------------------------------------------------------
// splitmix64_generator_engine_core
// Seeded 64-bit generator with next, bounded, split and load commands; one
// result per command, every result carrying the state left behind.
//
//   channel | dir | tdata / tuser                                   | transfer
//   in_     | in  | tuser cmd; tdata bound_a, bound_b, seeds        | tvalid && tready
//   out_    | out | tdata draw, child seed/gamma, seed, gamma       | tvalid && tready
//
// pacing is set by the single shared 32x32 multiplier, three passes per 64-bit
// product, two products per mix round; a bounded draw makes up to 1024 tries.
// reset: synchronous, active low; seed clears to zero, gamma to the golden gamma.
// stalls: one command at a time; a finished result waits in the output
// register while the next command is taken and worked on.
// ----------------------------------------------------------------------------
module splitmix64_generator_engine_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [62:0] bound_a, [125:63] bound_b, [189:126] load_seed, [253:190] load_gamma
  input  logic [sm64_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [sm64_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] draw_value, [127:64] child_seed, [191:128] child_gamma,
  // [255:192] seed_now, [319:256] gamma_now
  output logic [sm64_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sm64_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  sm64_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .dp_stat    (dp_stat),
    .dp_cmd     (dp_cmd)
  );

  sm64_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // a result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == DP_EMIT && out_tvalid) |-> out_tready)
    else $error("output register overwritten while full");

  // an accepted command blocks the input until its result is emitted
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a command is in flight");

  // input is only taken in the same cycle as a capture
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (dp_cmd.op == DP_CAPTURE))
    else $error("transfer without capture");
`endif

endmodule
